[rtl/csc_pkg.sv]
// Shared types and constants of the class separation scorer.
`timescale 1ns / 1ps

package csc_pkg;

	localparam int VALUE_BITS    = 16;
	localparam int COV_BITS      = 32;
	localparam int MASK_BITS     = 4;
	localparam int CNT_OUT_BITS  = 13;
	localparam int Q16_BITS      = 17;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int DIV_NUM_BITS  = 64;
	localparam int DIV_DEN_BITS  = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_MASK    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_COVERAGE = 1'b1;

	localparam logic [1:0] MARK_PAIRED   = 2'd0;
	localparam logic [1:0] MARK_UNPAIRED = 2'd1;
	localparam logic [1:0] MARK_UNKNOWN  = 2'd2;
	localparam logic [1:0] MARK_SPARE    = 2'd3;

	localparam logic [2:0] BASE_A         = 3'd0;
	localparam logic [2:0] BASE_C         = 3'd1;
	localparam logic [2:0] BASE_G         = 3'd2;
	localparam logic [2:0] BASE_U         = 3'd3;
	localparam logic [2:0] BASE_OTHER_LO  = 3'd4;
	localparam logic [2:0] BASE_OTHER_HI  = 3'd7;
	localparam logic [2:0] BASE_LAST_ACGU = 3'd3;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         value_finite;
		logic [COV_BITS-1:0]          coverage;
		logic [1:0]                   mark_class;
		logic [2:0]                   base_code;
		logic                         last;
	} in_item_t;

	typedef struct packed {
		logic                         scored;
		logic [CNT_OUT_BITS-1:0]      paired_count;
		logic [CNT_OUT_BITS-1:0]      unpaired_count;
		logic [Q16_BITS-1:0]          auroc;
		logic [Q16_BITS-1:0]          auprc;
		logic signed [VALUE_BITS-1:0] avg_paired;
		logic signed [VALUE_BITS-1:0] avg_unpaired;
	} out_item_t;

	typedef struct packed {
		logic                         open;
		logic signed [VALUE_BITS-1:0] value;
	} point_t;

	typedef struct packed {
		logic   keep;
		logic   last;
		point_t pt;
	} cmd_t;

	typedef struct packed {
		logic                    start;
		logic [DIV_NUM_BITS-1:0] num;
		logic [DIV_DEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIV_NUM_BITS-1:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_DECIDE,
		ST_MSETUP,
		ST_MRD,
		ST_MWR,
		ST_RUP,
		ST_EUP,
		ST_AFIN1,
		ST_AFIN2,
		ST_AFIN3,
		ST_ADIV,
		ST_AWAIT,
		ST_RDN,
		ST_EDN,
		ST_HDIV,
		ST_HWAIT,
		ST_PDIV,
		ST_PWAIT,
		ST_MPDIV,
		ST_MPWAIT,
		ST_MUDIV,
		ST_MUWAIT,
		ST_EMIT
	} back_state_t;

endpackage

[rtl/class_separation_scorer_top.sv]
// Top level of the class separation scorer.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------
// in       | sink      | in_valid / in_stall   | in_item (csc_pkg::in_item_t)
// out      | source    | out_valid / out_stall | out_item (csc_pkg::out_item_t)
// cfg      | sink      | cfg_we                | cfg_index, cfg_data
//
// A position is filtered combinationally and queued; the engine stores a kept
// point as it pops it, so rows stream in at one transaction per cycle while
// the engine is loading. At the end of a row the engine runs the merge
// passes (bound by the registered reads of the ping-pong point memories),
// the rank-sum scan, the precision walk (one divide per hit) and four more
// divides before the result is offered. Positions keep queuing in the
// four-entry queue meanwhile; in_stall rises when it fills. Reset is
// asynchronous and needs no clearing pass: only entries written in the
// current row are read. A stalled result holds in the output register.

module class_separation_scorer_top #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  csc_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output csc_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  logic [csc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [csc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// front to queue
	logic              push;
	csc_pkg::cmd_t     push_cmd;
	logic              q_full;

	// queue to engine
	logic              pop;
	csc_pkg::cmd_t     q_head;
	logic              q_empty;

	// engine to shared divider
	csc_pkg::div_req_t div_req;
	csc_pkg::div_rsp_t div_rsp;

	csc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	csc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	csc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	csc_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

endmodule

[rtl/csc_front.sv]
// Front end: configuration registers and position filter.
`timescale 1ns / 1ps

module csc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  csc_pkg::in_item_t                     in_item,
	input  logic                                  cfg_we,
	input  logic [csc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [csc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  q_full,
	output logic                                  push,
	output csc_pkg::cmd_t                         push_cmd
);

	logic [csc_pkg::MASK_BITS-1:0] base_mask_q;
	logic [csc_pkg::COV_BITS-1:0]  min_cov_q;
	logic                          mark_ok;
	logic                          base_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mask_q <= {csc_pkg::MASK_BITS{1'b1}};
			min_cov_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				csc_pkg::REG_BASE_MASK:    base_mask_q <= cfg_data[csc_pkg::MASK_BITS-1:0];
				csc_pkg::REG_MIN_COVERAGE: min_cov_q   <= cfg_data[csc_pkg::COV_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mark_ok = in_item.mark_class inside {csc_pkg::MARK_PAIRED, csc_pkg::MARK_UNPAIRED};
		base_ok = (in_item.base_code <= csc_pkg::BASE_LAST_ACGU) &&
			base_mask_q[in_item.base_code[1:0]];
		push_cmd.keep     = mark_ok && base_ok && in_item.value_finite &&
			(in_item.coverage >= min_cov_q);
		push_cmd.last     = in_item.last;
		push_cmd.pt.open  = (in_item.mark_class == csc_pkg::MARK_UNPAIRED);
		push_cmd.pt.value = in_item.value;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

[rtl/csc_queue.sv]
// Short transaction queue between the front end and the scoring engine.
`timescale 1ns / 1ps

module csc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  csc_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output csc_pkg::cmd_t head,
	output logic          empty
);

	csc_pkg::cmd_t                    entries_q [csc_pkg::QUEUE_DEPTH];
	logic [csc_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [csc_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [csc_pkg::QPTR_BITS:0]      count_q;

	assign full  = (count_q == (csc_pkg::QPTR_BITS+1)'(csc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/csc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module csc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csc_pkg::div_req_t req,
	output csc_pkg::div_rsp_t rsp
);

	localparam int NW   = csc_pkg::DIV_NUM_BITS;
	localparam int DW   = csc_pkg::DIV_DEN_BITS;
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     rem_sh;
	logic [DW+1:0]   diff;
	logic            ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[NW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[rtl/csc_back.sv]
// Scoring engine: point store, merge sort, rank sum, precision walk, means.
`timescale 1ns / 1ps

module csc_back #(
	parameter int MAX_POINTS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  csc_pkg::cmd_t      q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output csc_pkg::out_item_t out_item,
	output csc_pkg::div_req_t  div_req,
	input  csc_pkg::div_rsp_t  div_rsp
);

	localparam int VB  = csc_pkg::VALUE_BITS;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int IW  = AW + 2;
	localparam int S2W = 2 * CW + 1;
	localparam int SW  = VB + CW;
	localparam int APW = 33 + CW;
	localparam int NW  = csc_pkg::DIV_NUM_BITS;
	localparam int DW  = csc_pkg::DIV_DEN_BITS;

	csc_pkg::back_state_t state_q, state_d;

	csc_pkg::point_t mem0 [MAX_POINTS];
	csc_pkg::point_t mem1 [MAX_POINTS];
	csc_pkg::point_t d0a_q, d0b_q, d1a_q, d1b_q;
	csc_pkg::point_t ra, rb;

	logic                 we0, we1;
	logic [AW-1:0]        wa0, wa1, rd_a, rd_b;
	csc_pkg::point_t      wd0, wd1;

	logic [CW-1:0]        n_q, u_q, p_c;
	logic signed [SW-1:0] sp_q, su_q;
	logic                 load_write;
	logic                 scorable;

	logic [IW-1:0]        w_q, lo_q, mid_q, hi_q, a_q, b_q, k_q, i_q, rs_q;
	logic [IW-1:0]        k_nxt, lo_nxt, w2, mid_c, hi_c, lo_w, lo_2w, n_iw;
	logic                 src_q, take_a, blk_done, pass_done, sort_done;
	logic                 i_zero, i_end;

	logic signed [VB-1:0] rv_q;
	logic [CW-1:0]        hits_q, seen_q, found_q;
	logic [S2W-1:0]       pend_q, s2_q, uu_q, num_q;
	logic [2*CW-1:0]      den_q;
	logic [APW-1:0]       ap_sum_q;
	logic [S2W-1:0]       pend_run, pend_end, uu_c;
	logic [2*CW-1:0]      den_c;
	logic [SW-1:0]        sp_mag, su_mag;
	logic [VB-1:0]        q_lo;

	logic                 scored_q;
	logic [csc_pkg::Q16_BITS-1:0] auroc_q, auprc_q;
	logic signed [VB-1:0] mean_p_q, mean_u_q;
	logic                 out_valid_q;
	csc_pkg::out_item_t   out_item_q;

	// point store: one write and two registered reads per copy
	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa0] <= wd0;
		end
		if (we1) begin
			mem1[wa1] <= wd1;
		end
		d0a_q <= mem0[rd_a];
		d0b_q <= mem0[rd_b];
		d1a_q <= mem1[rd_a];
		d1b_q <= mem1[rd_b];
	end

	always_comb begin
		ra        = src_q ? d1a_q : d0a_q;
		rb        = src_q ? d1b_q : d0b_q;
		p_c       = n_q - u_q;
		n_iw      = IW'(n_q);
		scorable  = (u_q != '0) && (u_q != n_q);
		load_write = q_head.keep && (n_q < CW'(MAX_POINTS));
		take_a    = (b_q >= hi_q) || ((a_q < mid_q) && (ra.value <= rb.value));
		k_nxt     = k_q + 1'b1;
		blk_done  = (k_nxt == hi_q);
		w2        = w_q << 1;
		lo_nxt    = lo_q + w2;
		pass_done = (lo_nxt >= n_iw);
		sort_done = (w2 >= n_iw);
		lo_w      = lo_q + w_q;
		lo_2w     = lo_q + w2;
		mid_c     = (lo_w < n_iw) ? lo_w : n_iw;
		hi_c      = (lo_2w < n_iw) ? lo_2w : n_iw;
		i_zero    = (i_q == '0);
		i_end     = ((i_q + 1'b1) == n_iw);
		pend_run  = S2W'(rs_q + IW'(1) + i_q) * S2W'(hits_q);
		pend_end  = S2W'(rs_q + IW'(1) + n_iw) * S2W'(hits_q);
		uu_c      = S2W'(u_q) * (S2W'(u_q) + S2W'(1));
		den_c     = (2*CW)'(u_q) * (2*CW)'(p_c);
		sp_mag    = sp_q[SW-1] ? SW'(-sp_q) : SW'(sp_q);
		su_mag    = su_q[SW-1] ? SW'(-su_q) : SW'(su_q);
		q_lo      = div_rsp.quo[VB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		we0     = 1'b0;
		we1     = 1'b0;
		wa0     = k_q[AW-1:0];
		wa1     = k_q[AW-1:0];
		wd0     = take_a ? ra : rb;
		wd1     = take_a ? ra : rb;
		rd_a    = a_q[AW-1:0];
		rd_b    = b_q[AW-1:0];
		div_req = '0;
		case (state_q)
			csc_pkg::ST_LOAD: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (load_write) begin
						we0 = 1'b1;
						wa0 = n_q[AW-1:0];
						wd0 = q_head.pt;
					end
					if (q_head.last) begin
						state_d = csc_pkg::ST_DECIDE;
					end
				end
			end
			csc_pkg::ST_DECIDE: begin
				state_d = scorable ? csc_pkg::ST_MSETUP : csc_pkg::ST_EMIT;
			end
			csc_pkg::ST_MSETUP: state_d = csc_pkg::ST_MRD;
			csc_pkg::ST_MRD:    state_d = csc_pkg::ST_MWR;
			csc_pkg::ST_MWR: begin
				we0 = src_q;
				we1 = !src_q;
				if (blk_done) begin
					state_d = (pass_done && sort_done) ? csc_pkg::ST_RUP : csc_pkg::ST_MSETUP;
				end else begin
					state_d = csc_pkg::ST_MRD;
				end
			end
			csc_pkg::ST_RUP: begin
				rd_a    = i_q[AW-1:0];
				state_d = csc_pkg::ST_EUP;
			end
			csc_pkg::ST_EUP: begin
				state_d = i_end ? csc_pkg::ST_AFIN1 : csc_pkg::ST_RUP;
			end
			csc_pkg::ST_AFIN1: state_d = csc_pkg::ST_AFIN2;
			csc_pkg::ST_AFIN2: state_d = csc_pkg::ST_AFIN3;
			csc_pkg::ST_AFIN3: state_d = csc_pkg::ST_ADIV;
			csc_pkg::ST_ADIV: begin
				div_req.start = 1'b1;
				div_req.num   = NW'(num_q) << 16;
				div_req.den   = DW'(den_q) << 1;
				state_d       = csc_pkg::ST_AWAIT;
			end
			csc_pkg::ST_AWAIT: begin
				if (div_rsp.done) begin
					state_d = csc_pkg::ST_RDN;
				end
			end
			csc_pkg::ST_RDN: begin
				rd_a    = i_q[AW-1:0];
				state_d = csc_pkg::ST_EDN;
			end
			csc_pkg::ST_EDN: begin
				if (ra.open) begin
					state_d = csc_pkg::ST_HDIV;
				end else begin
					state_d = i_zero ? csc_pkg::ST_PDIV : csc_pkg::ST_RDN;
				end
			end
			csc_pkg::ST_HDIV: begin
				div_req.start = 1'b1;
				div_req.num   = NW'(found_q) << 32;
				div_req.den   = DW'(seen_q);
				state_d       = csc_pkg::ST_HWAIT;
			end
			csc_pkg::ST_HWAIT: begin
				if (div_rsp.done) begin
					state_d = i_zero ? csc_pkg::ST_PDIV : csc_pkg::ST_RDN;
				end
			end
			csc_pkg::ST_PDIV: begin
				div_req.start = 1'b1;
				div_req.num   = NW'(ap_sum_q);
				div_req.den   = DW'(u_q);
				state_d       = csc_pkg::ST_PWAIT;
			end
			csc_pkg::ST_PWAIT: begin
				if (div_rsp.done) begin
					state_d = csc_pkg::ST_MPDIV;
				end
			end
			csc_pkg::ST_MPDIV: begin
				div_req.start = 1'b1;
				div_req.num   = NW'(sp_mag);
				div_req.den   = DW'(p_c);
				state_d       = csc_pkg::ST_MPWAIT;
			end
			csc_pkg::ST_MPWAIT: begin
				if (div_rsp.done) begin
					state_d = csc_pkg::ST_MUDIV;
				end
			end
			csc_pkg::ST_MUDIV: begin
				div_req.start = 1'b1;
				div_req.num   = NW'(su_mag);
				div_req.den   = DW'(u_q);
				state_d       = csc_pkg::ST_MUWAIT;
			end
			csc_pkg::ST_MUWAIT: begin
				if (div_rsp.done) begin
					state_d = csc_pkg::ST_EMIT;
				end
			end
			csc_pkg::ST_EMIT: begin
				if (!out_valid_q) begin
					state_d = csc_pkg::ST_LOAD;
				end
			end
			default: state_d = csc_pkg::ST_LOAD;
		endcase
	end

	// row counters, class sums and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			u_q         <= '0;
			sp_q        <= '0;
			su_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == csc_pkg::ST_LOAD && !q_empty && load_write) begin
				n_q <= n_q + 1'b1;
				if (q_head.pt.open) begin
					u_q  <= u_q + 1'b1;
					su_q <= su_q + SW'(q_head.pt.value);
				end else begin
					sp_q <= sp_q + SW'(q_head.pt.value);
				end
			end
			if (state_q == csc_pkg::ST_EMIT && !out_valid_q) begin
				n_q         <= '0;
				u_q         <= '0;
				sp_q        <= '0;
				su_q        <= '0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			csc_pkg::ST_DECIDE: begin
				w_q      <= IW'(1);
				lo_q     <= '0;
				src_q    <= 1'b0;
				scored_q <= scorable;
				auroc_q  <= '0;
				auprc_q  <= '0;
				mean_p_q <= '0;
				mean_u_q <= '0;
			end
			csc_pkg::ST_MSETUP: begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				a_q   <= lo_q;
				b_q   <= mid_c;
				k_q   <= lo_q;
			end
			csc_pkg::ST_MWR: begin
				if (take_a) begin
					a_q <= a_q + 1'b1;
				end else begin
					b_q <= b_q + 1'b1;
				end
				k_q <= k_nxt;
				if (blk_done) begin
					if (pass_done) begin
						src_q  <= !src_q;
						w_q    <= w2;
						lo_q   <= '0;
						i_q    <= '0;
						s2_q   <= '0;
						pend_q <= '0;
						hits_q <= '0;
						rs_q   <= '0;
					end else begin
						lo_q <= lo_nxt;
					end
				end
			end
			csc_pkg::ST_RUP: begin
				s2_q   <= s2_q + pend_q;
				pend_q <= '0;
			end
			csc_pkg::ST_EUP: begin
				// close a tie run when the value changes
				if (i_zero) begin
					rv_q   <= ra.value;
					rs_q   <= '0;
					hits_q <= CW'(ra.open);
				end else if (ra.value == rv_q) begin
					hits_q <= hits_q + CW'(ra.open);
				end else begin
					pend_q <= pend_run;
					rv_q   <= ra.value;
					rs_q   <= i_q;
					hits_q <= CW'(ra.open);
				end
				if (!i_end) begin
					i_q <= i_q + 1'b1;
				end
			end
			csc_pkg::ST_AFIN1: begin
				s2_q   <= s2_q + pend_q;
				pend_q <= pend_end;
			end
			csc_pkg::ST_AFIN2: begin
				s2_q  <= s2_q + pend_q;
				uu_q  <= uu_c;
				den_q <= den_c;
			end
			csc_pkg::ST_AFIN3: begin
				num_q <= s2_q - uu_q;
			end
			csc_pkg::ST_AWAIT: begin
				if (div_rsp.done) begin
					auroc_q  <= div_rsp.quo[csc_pkg::Q16_BITS-1:0];
					i_q      <= n_iw - 1'b1;
					seen_q   <= '0;
					found_q  <= '0;
					ap_sum_q <= '0;
				end
			end
			csc_pkg::ST_EDN: begin
				seen_q <= seen_q + 1'b1;
				if (ra.open) begin
					found_q <= found_q + 1'b1;
				end else if (!i_zero) begin
					i_q <= i_q - 1'b1;
				end
			end
			csc_pkg::ST_HWAIT: begin
				if (div_rsp.done) begin
					ap_sum_q <= ap_sum_q + APW'(div_rsp.quo);
					if (!i_zero) begin
						i_q <= i_q - 1'b1;
					end
				end
			end
			csc_pkg::ST_PWAIT: begin
				if (div_rsp.done) begin
					auprc_q <= div_rsp.quo[csc_pkg::Q16_BITS+15:16];
				end
			end
			csc_pkg::ST_MPWAIT: begin
				if (div_rsp.done) begin
					mean_p_q <= sp_q[SW-1] ? VB'(-q_lo) : q_lo;
				end
			end
			csc_pkg::ST_MUWAIT: begin
				if (div_rsp.done) begin
					mean_u_q <= su_q[SW-1] ? VB'(-q_lo) : q_lo;
				end
			end
			csc_pkg::ST_EMIT: begin
				if (!out_valid_q) begin
					out_item_q.scored         <= scored_q;
					out_item_q.paired_count   <= csc_pkg::CNT_OUT_BITS'(p_c);
					out_item_q.unpaired_count <= csc_pkg::CNT_OUT_BITS'(u_q);
					out_item_q.auroc          <= auroc_q;
					out_item_q.auprc          <= auprc_q;
					out_item_q.avg_paired     <= mean_p_q;
					out_item_q.avg_unpaired   <= mean_u_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
